// File: src/gauge_needle_endpoints_core_assert.svh
// Assertion macros shared by the needle endpoint RTL.
// Needs a clock named clock and an active high reset named reset in scope.
`ifndef GAUGE_NEEDLE_ENDPOINTS_CORE_ASSERT_SVH
`define GAUGE_NEEDLE_ENDPOINTS_CORE_ASSERT_SVH

// checked only outside reset
`define GNE_ASSERT_RUN(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define GNE_ASSERT_ALL(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: src/gne_pkg.sv
// Shared types, constants and tables for the needle endpoint core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gne_pkg;

   localparam int ANGLE_FRAC_BITS_DEF = 8;
   localparam int COORD_FRAC_BITS_DEF = 4;

   localparam int REG_W   = 10;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;
   localparam int COORD_W = 16;

   typedef enum logic [1:0] {
      REG_CENTER_X      = 2'd0,
      REG_BASELINE_Y    = 2'd1,
      REG_NEEDLE_LEN    = 2'd2,
      REG_PIVOT_DEPTH   = 2'd3
   } reg_idx_type;

   localparam logic [REG_W-1:0] RST_CENTER_X      = 10'd80;
   localparam logic [REG_W-1:0] RST_BASELINE_Y    = 10'd80;
   localparam logic [REG_W-1:0] RST_NEEDLE_LEN    = 10'd105;
   localparam logic [REG_W-1:0] RST_PIVOT_DEPTH   = 10'd33;

   // angle path: 21 bits hold 180 degrees at up to 13 fraction bits
   localparam int ANG_W = 21;
   localparam int DEG_W = 25;
   localparam logic [DEG_W-1:0] DEG_TO_RAD_Q30 = 25'd18740330;

   localparam int CORDIC_STEPS = 28;
   localparam int CORDIC_W     = 33;
   localparam logic signed [CORDIC_W-1:0] GAIN_INV = 33'sd652032874;

   // quotient bits kept by the edge divider; anything larger saturates
   localparam int QUO_W = 20;
   localparam int DVS_W = 32;

   function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [4:0] idx);
      logic signed [CORDIC_W-1:0] v;
      case (idx)
         5'd0:  v = 33'sd843314856;
         5'd1:  v = 33'sd497837829;
         5'd2:  v = 33'sd263043836;
         5'd3:  v = 33'sd133525158;
         5'd4:  v = 33'sd67021686;
         5'd5:  v = 33'sd33543515;
         5'd6:  v = 33'sd16775850;
         5'd7:  v = 33'sd8388437;
         5'd8:  v = 33'sd4194282;
         5'd9:  v = 33'sd2097149;
         5'd10: v = 33'sd1048575;
         5'd11: v = 33'sd524287;
         5'd12: v = 33'sd262143;
         5'd13: v = 33'sd131071;
         5'd14: v = 33'sd65535;
         5'd15: v = 33'sd32767;
         5'd16: v = 33'sd16383;
         5'd17: v = 33'sd8191;
         5'd18: v = 33'sd4095;
         5'd19: v = 33'sd2047;
         5'd20: v = 33'sd1023;
         5'd21: v = 33'sd511;
         5'd22: v = 33'sd255;
         5'd23: v = 33'sd127;
         5'd24: v = 33'sd63;
         5'd25: v = 33'sd31;
         5'd26: v = 33'sd15;
         5'd27: v = 33'sd7;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// File: src/gauge_needle_endpoints_core.sv
// Needle endpoint core: angle to tip and bottom-edge crossing, fully pipelined.
// Depends on gne_pkg, gne_cordic, gne_div and the assertion macro header.
//
//  channel   dir   handshake              payload
//  req_      in    req_valid / req_stall  req_needle_angle
//  rsp_      out   rsp_valid / rsp_stall  rsp_tip_x, rsp_tip_y, rsp_edge_x,
//                                         rsp_edge_y, rsp_edge_clipped
//  csr       in    APB psel/penable       center_x, baseline_y, length,
//                                         pivot_depth at 0x0/0x4/0x8/0xC
//
// One transfer per cycle in and out unless the output stalls; stages: input reg,
// radian multiply, 29 CORDIC stages, product reg, 22 divider stages, output reg.
// The 28-step CORDIC and the 20-bit edge divider set the depth.
// A single enable moves every stage; it drops only while the output holds a
// result and rsp_stall is high, and req_stall is its inverse.
// Reset is synchronous; it clears valid bits and restores the registers.
`timescale 1ns / 1ps
`default_nettype none

`include "gauge_needle_endpoints_core_assert.svh"

module gauge_needle_endpoints_core #(
   parameter int ANGLE_FRAC_BITS = gne_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int COORD_FRAC_BITS = gne_pkg::COORD_FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [15:0]                       req_needle_angle,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [gne_pkg::COORD_W-1:0]     rsp_tip_x,
   output logic signed [gne_pkg::COORD_W-1:0]     rsp_tip_y,
   output logic signed [gne_pkg::COORD_W-1:0]     rsp_edge_x,
   output logic signed [gne_pkg::COORD_W-1:0]     rsp_edge_y,
   output logic                                   rsp_edge_clipped,
   // register port
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [gne_pkg::ADDR_W-1:0]        paddr,
   input  wire logic [gne_pkg::DATA_W-1:0]        pwdata,
   output logic [gne_pkg::DATA_W-1:0]             prdata,
   output logic                                   pready
);

   localparam int AF    = ANGLE_FRAC_BITS;
   localparam int CF    = COORD_FRAC_BITS;
   localparam int RW    = gne_pkg::REG_W;
   localparam int AW    = gne_pkg::ANG_W;
   localparam int PRW   = AW + gne_pkg::DEG_W;
   localparam int CW    = gne_pkg::CORDIC_W;
   localparam int MW    = CW + RW + 1;
   localparam int MAG_W = MW + CF;
   localparam int DVD_W = MAG_W + 1;
   localparam int OW    = gne_pkg::COORD_W;
   localparam int QW    = gne_pkg::QUO_W;
   localparam int EW    = QW + 2;
   localparam int SH    = 30 - CF;
   localparam int DSIDE_W = 3 * OW + 3;

   localparam logic [AW-1:0]  RIGHT = AW'(90 << AF);
   localparam logic [AW-1:0]  LIMIT = AW'(180 << AF);
   localparam logic [PRW-1:0] RAD_HALF = PRW'(64'd1 << (AF - 1));
   localparam logic signed [MW-1:0] RND_HALF = MW'(64'd1 << (SH - 1));
   localparam logic signed [EW-1:0] SAT_HI = EW'(32767);
   localparam logic signed [EW-1:0] SAT_LO = -EW'(32768);

   // ---------------- register file ----------------
   logic [RW-1:0] center_ff, baseline_ff, length_ff, pivot_ff;
   logic          csr_wr;

   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff   <= gne_pkg::RST_CENTER_X;
         baseline_ff <= gne_pkg::RST_BASELINE_Y;
         length_ff   <= gne_pkg::RST_NEEDLE_LEN;
         pivot_ff    <= gne_pkg::RST_PIVOT_DEPTH;
      end else if (csr_wr) begin
         case (gne_pkg::reg_idx_type'(paddr[3:2]))
            gne_pkg::REG_CENTER_X:      center_ff   <= pwdata[RW-1:0];
            gne_pkg::REG_BASELINE_Y:    baseline_ff <= pwdata[RW-1:0];
            gne_pkg::REG_NEEDLE_LEN:    length_ff   <= pwdata[RW-1:0];
            gne_pkg::REG_PIVOT_DEPTH:   pivot_ff    <= pwdata[RW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (gne_pkg::reg_idx_type'(paddr[3:2]))
         gne_pkg::REG_CENTER_X:      prdata = gne_pkg::DATA_W'(center_ff);
         gne_pkg::REG_BASELINE_Y:    prdata = gne_pkg::DATA_W'(baseline_ff);
         gne_pkg::REG_NEEDLE_LEN:    prdata = gne_pkg::DATA_W'(length_ff);
         gne_pkg::REG_PIVOT_DEPTH:   prdata = gne_pkg::DATA_W'(pivot_ff);
         default:                    prdata = '0;
      endcase
   end

   // ---------------- pipeline enable ----------------
   logic en;
   logic rsp_valid_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // ---------------- stage A: input register ----------------
   logic [15:0] ang_ff;
   logic        va_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff <= req_needle_angle;
      end
   end

   // out-of-range angles fold to straight up; t = a - 90, split into sign and size
   logic [AW-1:0]  a_ext, a_fix, mag_in;
   logic           neg_in;
   logic [PRW-1:0] prod_in;

   assign a_ext   = AW'(ang_ff);
   assign a_fix   = (a_ext == '0 || a_ext >= LIMIT) ? RIGHT : a_ext;
   assign neg_in  = a_fix < RIGHT;
   assign mag_in  = neg_in ? RIGHT - a_fix : a_fix - RIGHT;
   assign prod_in = PRW'(mag_in) * PRW'(gne_pkg::DEG_TO_RAD_Q30);

   // ---------------- stage B: degrees to radians product ----------------
   logic [PRW-1:0] prod_ff;
   logic           negb_ff;
   logic           vb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         negb_ff <= neg_in;
      end
   end

   logic signed [CW-1:0] theta;
   logic [PRW-1:0]       theta_wide;

   assign theta_wide = (prod_ff + RAD_HALF) >> AF;
   assign theta      = $signed(theta_wide[CW-1:0]);

   // ---------------- CORDIC ----------------
   logic                 vc;
   logic signed [CW-1:0] cos_c, sin_c;
   logic                 negc;

   gne_cordic #(
      .SIDE_W (1)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vb_ff),
      .in_theta  (theta),
      .in_side   (negb_ff),
      .out_valid (vc),
      .out_cos   (cos_c),
      .out_sin   (sin_c),
      .out_side  (negc)
   );

   // ---------------- stage D: length and pivot products ----------------
   logic signed [CW-1:0] s_fix;
   logic signed [MW-1:0] ls_in, lc_in, ps_in;

   assign s_fix = negc ? -sin_c : sin_c;
   assign ls_in = $signed({1'b0, length_ff}) * s_fix;
   assign lc_in = $signed({1'b0, length_ff}) * cos_c;
   assign ps_in = $signed({1'b0, pivot_ff}) * s_fix;

   logic signed [MW-1:0] ls_ff, lc_ff, ps_ff;
   logic signed [CW-1:0] cd_ff;
   logic                 vd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (en) begin
         vd_ff <= vc;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ls_ff <= ls_in;
         lc_ff <= lc_in;
         ps_ff <= ps_in;
         cd_ff <= cos_c;
      end
   end

   // ---------------- tip, baseline and divider operands ----------------
   logic signed [MW-1:0] ls_rnd, lc_rnd;
   logic [OW-1:0]        cx_w, base_w, by_w;
   logic [OW-1:0]        tx_in, ty_in, ey_in;
   logic                 num_zero, num_neg, c_le0;
   logic [MW-1:0]        ps_abs;
   logic [DVD_W-1:0]     dividend;
   logic [gne_pkg::DVS_W-1:0] divisor;

   assign ls_rnd = (ls_ff + RND_HALF) >>> SH;
   assign lc_rnd = (lc_ff + RND_HALF) >>> SH;

   // tip and baseline wrap to 16 bits
   assign cx_w   = OW'(32'(center_ff) << CF);
   assign base_w = OW'(32'(baseline_ff) << CF);
   assign by_w   = OW'((32'(baseline_ff) + 32'(pivot_ff)) << CF);
   assign tx_in  = cx_w + OW'(ls_rnd);
   assign ty_in  = by_w - OW'(lc_rnd);
   assign ey_in  = base_w;

   // edge: q = round(pivot * S * 2^CF / C), ties away from zero
   assign num_zero = (ps_ff == '0);
   assign num_neg  = ps_ff[MW-1];
   assign c_le0    = cd_ff[CW-1] || (cd_ff == '0);
   assign ps_abs   = num_neg ? MW'(-ps_ff) : MW'(ps_ff);
   assign divisor  = cd_ff[gne_pkg::DVS_W-1:0];
   assign dividend = (DVD_W'(ps_abs) << CF) + DVD_W'(divisor >> 1);

   logic               vdv;
   logic [QW-1:0]      quot;
   logic               ovf;
   logic [DSIDE_W-1:0] dside;

   gne_div #(
      .DVD_W  (DVD_W),
      .SIDE_W (DSIDE_W)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (vd_ff),
      .in_dividend (dividend),
      .in_divisor  (divisor),
      .in_side     ({tx_in, ty_in, ey_in, num_zero, c_le0, num_neg}),
      .out_valid   (vdv),
      .out_quot    (quot),
      .out_ovf     (ovf),
      .out_side    (dside)
   );

   // ---------------- edge x assembly and saturation ----------------
   logic [OW-1:0]        tx_q, ty_q, ey_q;
   logic                 zero_q, cle0_q, neg_q;
   logic signed [EW-1:0] cx_e, q_e, e_sum;
   logic [OW-1:0]        ex_in;
   logic                 clip_in;

   assign {tx_q, ty_q, ey_q, zero_q, cle0_q, neg_q} = dside;
   assign cx_e  = $signed(EW'(32'(center_ff) << CF));
   assign q_e   = $signed(EW'(quot));
   assign e_sum = neg_q ? cx_e - q_e : cx_e + q_e;

   always_comb begin
      if (zero_q) begin
         ex_in   = OW'(cx_e);
         clip_in = 1'b0;
      end else if (cle0_q || ovf) begin
         ex_in   = neg_q ? OW'(SAT_LO) : OW'(SAT_HI);
         clip_in = 1'b1;
      end else if (e_sum > SAT_HI) begin
         ex_in   = OW'(SAT_HI);
         clip_in = 1'b1;
      end else if (e_sum < SAT_LO) begin
         ex_in   = OW'(SAT_LO);
         clip_in = 1'b1;
      end else begin
         ex_in   = OW'(e_sum);
         clip_in = 1'b0;
      end
   end

   // ---------------- output register ----------------
   logic [OW-1:0] tx_ff, ty_ff, ex_ff, ey_ff;
   logic          clip_ff;
   logic          ex_at_limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vdv;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tx_ff   <= tx_q;
         ty_ff   <= ty_q;
         ex_ff   <= ex_in;
         ey_ff   <= ey_q;
         clip_ff <= clip_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tip_x        = $signed(tx_ff);
   assign rsp_tip_y        = $signed(ty_ff);
   assign rsp_edge_x       = $signed(ex_ff);
   assign rsp_edge_y       = $signed(ey_ff);
   assign rsp_edge_clipped = clip_ff;

   assign ex_at_limit = (ex_ff == OW'(SAT_HI)) || (ex_ff == OW'(SAT_LO));

   `GNE_ASSERT_ALL(a_reset_clears_rsp, reset |=> !rsp_valid, "result valid after reset")
   `GNE_ASSERT_RUN(a_clip_saturates, rsp_valid && clip_ff |-> ex_at_limit, "clip not at a limit")
   `GNE_ASSERT_RUN(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(ex_ff), "rsp moved")

endmodule

`default_nettype wire

// File: src/gne_cordic.sv
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage after the input register.
// Uses gne_pkg for widths, gain and arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module gne_cordic #(
   parameter int SIDE_W = 1
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 en,
   input  wire logic                                 in_valid,
   input  wire logic signed [gne_pkg::CORDIC_W-1:0]  in_theta,
   input  wire logic [SIDE_W-1:0]                    in_side,
   output logic                                      out_valid,
   output logic signed [gne_pkg::CORDIC_W-1:0]       out_cos,
   output logic signed [gne_pkg::CORDIC_W-1:0]       out_sin,
   output logic [SIDE_W-1:0]                         out_side
);

   localparam int N = gne_pkg::CORDIC_STEPS;
   localparam int W = gne_pkg::CORDIC_W;

   logic signed [W-1:0] x_ff [0:N];
   logic signed [W-1:0] y_ff [0:N];
   logic signed [W-1:0] z_ff [0:N];
   logic [SIDE_W-1:0]   side_ff [0:N];
   logic                valid_ff [0:N];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= gne_pkg::GAIN_INV;
         y_ff[0]    <= '0;
         z_ff[0]    <= in_theta;
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      logic signed [W-1:0] dx, dy, ang;
      logic signed [W-1:0] x_in, y_in, z_in;

      assign dx  = y_ff[i] >>> i;
      assign dy  = x_ff[i] >>> i;
      assign ang = gne_pkg::atan_q30(5'(i));

      always_comb begin
         if (!z_ff[i][W-1]) begin
            x_in = x_ff[i] - dx;
            y_in = y_ff[i] + dy;
            z_in = z_ff[i] - ang;
         end else begin
            x_in = x_ff[i] + dx;
            y_in = y_ff[i] - dy;
            z_in = z_ff[i] + ang;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = valid_ff[N];
   assign out_cos   = x_ff[N];
   assign out_sin   = y_ff[N];
   assign out_side  = side_ff[N];

endmodule

`default_nettype wire

// File: src/gne_div.sv
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
// Uses gne_pkg for the quotient and divisor widths; assertion macros from the header.
`timescale 1ns / 1ps
`default_nettype none

`include "gauge_needle_endpoints_core_assert.svh"

module gne_div #(
   parameter int DVD_W  = 49,
   parameter int SIDE_W = 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire logic [DVD_W-1:0]              in_dividend,
   input  wire logic [gne_pkg::DVS_W-1:0]     in_divisor,
   input  wire logic [SIDE_W-1:0]             in_side,
   output logic                               out_valid,
   output logic [gne_pkg::QUO_W-1:0]          out_quot,
   output logic                               out_ovf,
   output logic [SIDE_W-1:0]                  out_side
);

   localparam int QW = gne_pkg::QUO_W;
   localparam int DV = gne_pkg::DVS_W;
   localparam int W  = (DVD_W > DV + QW) ? DVD_W : DV + QW;
   localparam int LAST = QW + 1;

   logic [W-1:0]      rem_ff  [0:LAST];
   logic [DV-1:0]     div_ff  [0:LAST];
   logic [QW-1:0]     quot_ff [0:LAST];
   logic              ovf_ff  [0:LAST];
   logic [SIDE_W-1:0] side_ff [0:LAST];
   logic              valid_ff [0:LAST];

   logic ovf_in;
   logic rem_ok;
   logic div_zero;

   assign ovf_in = rem_ff[0] >= (W'(div_ff[0]) << QW);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
         valid_ff[1] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         valid_ff[1] <= valid_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= W'(in_dividend);
         div_ff[0]  <= in_divisor;
         quot_ff[0] <= '0;
         ovf_ff[0]  <= 1'b0;
         side_ff[0] <= in_side;
         rem_ff[1]  <= rem_ff[0];
         div_ff[1]  <= div_ff[0];
         quot_ff[1] <= '0;
         ovf_ff[1]  <= ovf_in;
         side_ff[1] <= side_ff[0];
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_bit
      localparam int K = QW - 1 - j;
      logic [W-1:0] sub;
      logic         take;
      logic [W-1:0] rem_in;

      assign sub    = W'(div_ff[j+1]) << K;
      assign take   = rem_ff[j+1] >= sub;
      assign rem_in = take ? rem_ff[j+1] - sub : rem_ff[j+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j+2] <= 1'b0;
         end else if (en) begin
            valid_ff[j+2] <= valid_ff[j+1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+2]  <= rem_in;
            div_ff[j+2]  <= div_ff[j+1];
            quot_ff[j+2] <= quot_ff[j+1] | (QW'(take) << K);
            ovf_ff[j+2]  <= ovf_ff[j+1];
            side_ff[j+2] <= side_ff[j+1];
         end
      end
   end

   assign out_valid = valid_ff[LAST];
   assign out_quot  = quot_ff[LAST];
   assign out_ovf   = ovf_ff[LAST];
   assign out_side  = side_ff[LAST];

   assign rem_ok   = rem_ff[LAST] < W'(div_ff[LAST]);
   assign div_zero = (div_ff[LAST] == '0);

   `GNE_ASSERT_RUN(a_rem_below_div, valid_ff[LAST] && !ovf_ff[LAST] |-> rem_ok, "bad remainder")
   `GNE_ASSERT_RUN(a_div_zero_ovf, valid_ff[LAST] && div_zero |-> ovf_ff[LAST], "zero divisor")
   `GNE_ASSERT_ALL(a_div_reset, reset |=> !out_valid, "divider valid after reset")

endmodule

`default_nettype wire

// File: sim/tb_gauge_needle_endpoints_core.sv
// Self-checking bench for gauge_needle_endpoints_core: angles in, endpoints out.
// Depends on gne_pkg and the core RTL; an in-bench fixed-point predictor produces expected endpoints.
`timescale 1ns / 1ps

module tb_gauge_needle_endpoints_core;

   localparam int ANG_FB     = gne_pkg::ANGLE_FRAC_BITS_DEF;
   localparam int CRD_FB     = gne_pkg::COORD_FRAC_BITS_DEF;
   localparam int CW         = gne_pkg::COORD_W;
   localparam int RW         = gne_pkg::REG_W;
   localparam int AW         = gne_pkg::ADDR_W;
   localparam int DW         = gne_pkg::DATA_W;
   localparam int PIPE_DEPTH = 55;          // core pipeline depth, counted in registers
   localparam int STALL_LIMIT = 4000;       // cycles with no transfer before giving up
   localparam int HOLD_CYCLES = 300;        // long output back-pressure stretch

   typedef struct {
      logic signed [CW-1:0] tip_x;
      logic signed [CW-1:0] tip_y;
      logic signed [CW-1:0] edge_x;
      logic signed [CW-1:0] edge_y;
      logic                 edge_clipped;
   } endpoint_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [15:0]          req_needle_angle = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [CW-1:0] rsp_tip_x, rsp_tip_y, rsp_edge_x, rsp_edge_y;
   logic                 rsp_edge_clipped;
   logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [AW-1:0]        paddr = '0;
   logic [DW-1:0]        pwdata = '0;
   logic [DW-1:0]        prdata;
   logic                 pready;

   gauge_needle_endpoints_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_needle_angle(req_needle_angle),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_tip_x(rsp_tip_x), .rsp_tip_y(rsp_tip_y),
      .rsp_edge_x(rsp_edge_x), .rsp_edge_y(rsp_edge_y),
      .rsp_edge_clipped(rsp_edge_clipped),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // bench copy of the geometry registers, updated with each register write
   logic [RW-1:0] cfg_center, cfg_base, cfg_len, cfg_pivot;
   longint        arctan_tab [0:27];

   logic [15:0]  angle_queue [$];      // angles waiting to be offered
   endpoint_type endpoint_queue [$];   // predicted endpoints, oldest first

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit long_hold_req = 1'b0;
   bit long_hold_done = 1'b0;
   int hold_cnt = 0;
   int mismatches = 0;
   int angles_sent = 0;
   int endpoints_seen = 0;
   int clipped_seen = 0;
   int quiet_cycles = 0;

   // Angle -> endpoints, Q2.30 CORDIC with floor shifts, Q12.4 coordinates.
   function automatic endpoint_type predict_endpoints(input logic [15:0] ang);
      endpoint_type r;
      longint a, t, m, theta, x, y, z, dx, dy, c, s, cx, tx, ty, ey, num, mag, q, ex;
      bit clip;
      a = longint'(ang);
      clip = 1'b0;
      // out of range angles (zero, 180 and up) fall back to straight up
      if (a == 0 || a >= (longint'(180) <<< ANG_FB))
         a = longint'(90) <<< ANG_FB;
      t = a - (longint'(90) <<< ANG_FB);
      m = (t < 0) ? -t : t;
      theta = (m * 18740330 + (longint'(1) <<< (ANG_FB - 1))) >>> ANG_FB;
      x = 652032874;
      y = 0;
      z = theta;
      for (int i = 0; i < 28; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - arctan_tab[i];
         end else begin
            x = x + dx; y = y - dy; z = z + arctan_tab[i];
         end
      end
      c = x;
      s = (t < 0) ? -y : y;
      cx = longint'(cfg_center) <<< CRD_FB;
      tx = cx + ((longint'(cfg_len) * s + (longint'(1) <<< (29 - CRD_FB))) >>> (30 - CRD_FB));
      ty = ((longint'(cfg_base) + longint'(cfg_pivot)) <<< CRD_FB)
           - ((longint'(cfg_len) * c + (longint'(1) <<< (29 - CRD_FB))) >>> (30 - CRD_FB));
      ey = longint'(cfg_base) <<< CRD_FB;
      num = longint'(cfg_pivot) * s * (longint'(1) <<< CRD_FB);
      if (num == 0) begin
         ex = cx;
      end else if (c <= 0) begin
         // needle flat: crossing runs off to the side of s
         ex = (num > 0) ? 32767 : -32768;
         clip = 1'b1;
      end else begin
         mag = (num < 0) ? -num : num;
         q = (mag + c / 2) / c;
         ex = cx + ((num < 0) ? -q : q);
         if (ex > 32767) begin
            ex = 32767; clip = 1'b1;
         end else if (ex < -32768) begin
            ex = -32768; clip = 1'b1;
         end
      end
      r.tip_x = tx[15:0];
      r.tip_y = ty[15:0];
      r.edge_x = ex[15:0];
      r.edge_y = ey[15:0];
      r.edge_clipped = clip;
      return r;
   endfunction

   // Input driver: offers the next queued angle, idling at random.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            // transfer on this edge: the registers are stable, predict now
            endpoint_queue.push_back(predict_endpoints(req_needle_angle));
            angles_sent++;
         end
         if (angle_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_needle_angle <= angle_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Output monitor: checks each endpoint transfer, then picks the next stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            endpoints_seen++;
            if (rsp_edge_clipped)
               clipped_seen++;
            if (endpoint_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected endpoint transfer at %0t", $time);
            end else begin
               endpoint_type e;
               e = endpoint_queue.pop_front();
               if (rsp_tip_x !== e.tip_x || rsp_tip_y !== e.tip_y ||
                   rsp_edge_x !== e.edge_x || rsp_edge_y !== e.edge_y ||
                   rsp_edge_clipped !== e.edge_clipped) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"ERROR at %0t: exp tip (%0d,%0d) edge (%0d,%0d) clip %0b,",
                               " got tip (%0d,%0d) edge (%0d,%0d) clip %0b"},
                              $time, e.tip_x, e.tip_y, e.edge_x, e.edge_y, e.edge_clipped,
                              rsp_tip_x, rsp_tip_y, rsp_edge_x, rsp_edge_y, rsp_edge_clipped);
               end
            end
         end
         // long hold-off lets the pipe fill and push back on the input
         if (long_hold_req && !long_hold_done) begin
            long_hold_done <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Watchdog: counts cycles with no transfer on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog expired with %0d endpoints outstanding", endpoint_queue.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // APB write: setup cycle, then access cycle; register lands when both are high.
   task automatic write_reg(input gne_pkg::reg_idx_type idx, input logic [RW-1:0] val);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= AW'(4 * int'(idx));
      pwdata <= DW'(val);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         gne_pkg::REG_CENTER_X:    cfg_center = val;
         gne_pkg::REG_BASELINE_Y:  cfg_base = val;
         gne_pkg::REG_NEEDLE_LEN:  cfg_len = val;
         gne_pkg::REG_PIVOT_DEPTH: cfg_pivot = val;
         default: ;
      endcase
   endtask

   task automatic set_geometry(input logic [RW-1:0] cx, input logic [RW-1:0] by,
                               input logic [RW-1:0] len, input logic [RW-1:0] pv);
      write_reg(gne_pkg::REG_CENTER_X, cx);
      write_reg(gne_pkg::REG_BASELINE_Y, by);
      write_reg(gne_pkg::REG_NEEDLE_LEN, len);
      write_reg(gne_pkg::REG_PIVOT_DEPTH, pv);
   endtask

   // Mostly in-range angles; some full 16-bit values to hit the fallback.
   task automatic queue_random_angles(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(7) == 0)
            angle_queue.push_back(16'($urandom));
         else
            angle_queue.push_back(16'($urandom_range(46079, 1)));
      end
   endtask

   // Wait for the pipe to drain before touching registers again.
   task automatic drain();
      while (angle_queue.size() > 0 || req_valid || endpoint_queue.size() > 0)
         @(posedge clock);
      repeat (PIPE_DEPTH + 5) @(posedge clock);
   endtask

   initial begin
      arctan_tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                     16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                     131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
                     127, 63, 31, 15, 7};
      cfg_center = gne_pkg::RST_CENTER_X;
      cfg_base = gne_pkg::RST_BASELINE_Y;
      cfg_len = gne_pkg::RST_NEEDLE_LEN;
      cfg_pivot = gne_pkg::RST_PIVOT_DEPTH;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Phase 1: reset geometry, directed corners, sender 36% / receiver 68% idle.
      send_idle_pct = 36;
      recv_idle_pct = 68;
      angle_queue.push_back(16'd0);              // zero -> treated as 90
      angle_queue.push_back(16'd1);              // smallest angle, near horizontal
      angle_queue.push_back(16'd46079);          // just under 180
      angle_queue.push_back(16'd46080);          // exactly 180 -> 90
      angle_queue.push_back(16'hFFFF);           // all ones -> 90
      angle_queue.push_back(16'h8000);
      angle_queue.push_back(16'h7FFF);
      angle_queue.push_back(16'd23040);          // straight up
      angle_queue.push_back(16'd23039);
      angle_queue.push_back(16'd23041);
      angle_queue.push_back(16'd256);            // one degree
      angle_queue.push_back(16'd11520);          // 45 degrees
      angle_queue.push_back(16'd34560);          // 135 degrees
      queue_random_angles(400);
      repeat (50) @(posedge clock);
      long_hold_req = 1'b1;
      drain();

      // Phase 2: far pivot and long needle, edge clipping likely; roles swapped.
      set_geometry(10'd0, 10'd0, 10'd1023, 10'd1023);
      send_idle_pct = 68;
      recv_idle_pct = 36;
      angle_queue.push_back(16'd1);
      angle_queue.push_back(16'd46079);
      queue_random_angles(400);
      drain();

      // Phase 3: opposite extremes, zero pivot so the crossing sits on the axis.
      set_geometry(10'd1023, 10'd1023, 10'd1, 10'd0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      angle_queue.push_back(16'd1);
      queue_random_angles(250);
      drain();

      // Phase 4: random geometry, full rate.
      set_geometry(10'($urandom), 10'($urandom), 10'($urandom_range(1023, 1)),
                   10'($urandom));
      queue_random_angles(300);
      drain();

      $display("Covered %0d angle transfers over four geometries, %0d clipped crossings.",
               angles_sent, clipped_seen);
      $display("Endpoints checked: %0d, mismatches: %0d", endpoints_seen, mismatches);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+src
src/gne_pkg.sv
src/gne_cordic.sv
src/gne_div.sv
src/gauge_needle_endpoints_core.sv
sim/tb_gauge_needle_endpoints_core.sv
